### rtl/core/swss_pkg.sv
`default_nettype none
package swss_pkg;

   localparam int ValW = 24;
   localparam logic signed [ValW-1:0] ValMax = 24'sh7FFFFF;
   localparam logic signed [ValW-1:0] ValMin = -24'sh800000;

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_SPLASH  = 2'd1,
      MODE_RESTART = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CSR_COUNT   = 3'd0,
      CSR_TENSION = 3'd1,
      CSR_DAMPING = 3'd2,
      CSR_INIT    = 3'd3,
      CSR_CEILING = 3'd4,
      CSR_STEP    = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RESTART,
      ST_SPLASH,
      ST_SPRING,
      ST_SPREAD,
      ST_EMIT
   } state_type;

   function automatic logic signed [ValW-1:0] sat24(input logic signed [47:0] v);
      if (v > 48'(ValMax)) return ValMax;
      if (v < 48'(ValMin)) return ValMin;
      return v[ValW-1:0];
   endfunction

endpackage
`default_nettype wire

### rtl/core/swss_mem.sv
`default_nettype none
module swss_mem #(
   parameter int Depth = 64,
   parameter int AddrW = 6
) (
   input  wire              clock,
   input  wire              wr_en,
   input  wire [AddrW-1:0]  wr_addr,
   input  wire [47:0]       wr_data,
   input  wire [AddrW-1:0]  rd_addr,
   output logic [47:0]      rd_data
);
   logic [47:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/core/spring_water_surface_sim_core.sv
`default_nettype none
// spring-mass water surface simulation core
// req_ channel: mode, column, splash_speed; a transaction is taken when
// req_valid is high and req_stall low.
// rsp_ channel: column_index, level, last; one transaction per column in use,
// emitted only for a tick, in column order, last flagged on the final one.
// csr_ channel: register index and data written when csr_valid and csr_ready.
// a tick runs a spring sweep, then SPREAD_PASSES spread sweeps (none for a
// single column), each doing one memory read and one write per column through
// a single-port-read memory holding level and speed, then an emit sweep that
// also waits out rsp_stall.
// a splash reads its column and writes it back; a restart writes all MAX_COLUMNS entries, one column a cycle.
// after reset a restart pass sweeps all MAX_COLUMNS entries before req_ is
// taken. a stalled rsp_ transaction holds its payload and the emit sweep waits.
module spring_water_surface_sim_core #(
   parameter int MAX_COLUMNS   = 64,
   parameter int SPREAD_PASSES = 8
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire [1:0]          req_mode,
   input  wire [5:0]          req_column,
   input  wire signed [23:0]  req_splash_speed,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic [5:0]         rsp_column_index,
   output logic signed [23:0] rsp_level,
   output logic               rsp_last,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire [2:0]          csr_index,
   input  wire [22:0]         csr_data
);
   import swss_pkg::*;

   localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int CW = AW + 1;
   localparam int PW = (SPREAD_PASSES > 1) ? $clog2(SPREAD_PASSES) : 1;

   logic [6:0]  count_ff;
   logic [15:0] tension_ff, damping_ff, step_ff;
   logic [22:0] init_ff, ceiling_ff;
   logic signed [23:0] rest_ff, rest_in;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 7'd64; tension_ff <= 16'd1638; damping_ff <= 16'd1638;
         init_ff <= 23'd2048; ceiling_ff <= 23'd43008; step_ff <= 16'd32;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_COUNT:   count_ff <= csr_data[6:0];
            CSR_TENSION: tension_ff <= csr_data[15:0];
            CSR_DAMPING: damping_ff <= csr_data[15:0];
            CSR_INIT:    init_ff <= csr_data;
            CSR_CEILING: ceiling_ff <= csr_data;
            CSR_STEP:    step_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   logic [CW-1:0] n;
   always_comb begin
      if (count_ff == 7'd0) n = CW'(1);
      else if (32'(count_ff) > MAX_COLUMNS) n = CW'(MAX_COLUMNS);
      else n = CW'(count_ff);
   end

   state_type state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;      // read index
   logic [PW:0]   pass_ff, pass_in;
   logic [AW-1:0] col_ff, col_in;
   logic signed [23:0] sp_ff, sp_in;
   logic          rv_ff, rv_in;        // read data valid for column ra_ff
   logic [AW-1:0] ra_ff, ra_in;        // address of read data
   // spread pipeline: snapshot levels of previous and current column
   logic signed [23:0] prev_ff, prev_in;
   logic          hp_ff, hp_in;        // prev holds a pending column
   logic signed [23:0] pspd_ff, pspd_in;
   logic signed [25:0] padd_ff, padd_in;
   logic [AW-1:0] pa_ff, pa_in;
   // spring intermediate
   logic signed [39:0] pull_ff, pull_in, drag_ff, drag_in;
   logic signed [23:0] slv_ff, slv_in, ssp_ff, ssp_in;
   logic [AW-1:0] sa_ff, sa_in;
   logic          s2_ff, s2_in;
   logic          ov_ff, ov_in;
   logic [AW-1:0] oa_ff, oa_in;
   logic signed [23:0] ol_ff, ol_in;
   logic          ol_last_ff, ol_last_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [47:0]   wr_data, rd_data;

   swss_mem #(.Depth(MAX_COLUMNS), .AddrW(AW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   wire signed [23:0] rd_lv = rd_data[47:24];
   wire signed [23:0] rd_sp = rd_data[23:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RESTART; idx_ff <= '0; rv_ff <= 1'b0; ov_ff <= 1'b0;
         hp_ff <= 1'b0; s2_ff <= 1'b0; pass_ff <= '0;
         rest_ff <= 24'sd2048;
      end else begin
         state_ff <= state_in; idx_ff <= idx_in; rv_ff <= rv_in; ov_ff <= ov_in;
         hp_ff <= hp_in; s2_ff <= s2_in; pass_ff <= pass_in; rest_ff <= rest_in;
      end
      col_ff <= col_in; sp_ff <= sp_in; ra_ff <= ra_in;
      prev_ff <= prev_in; pspd_ff <= pspd_in; padd_ff <= padd_in; pa_ff <= pa_in;
      pull_ff <= pull_in; drag_ff <= drag_in; slv_ff <= slv_in; ssp_ff <= ssp_in;
      sa_ff <= sa_in; oa_ff <= oa_in; ol_ff <= ol_in; ol_last_ff <= ol_last_in;
   end

   logic signed [25:0] d, q, tot;
   logic signed [23:0] nspd, nlv;
   logic signed [47:0] tmp;
   logic out_free;

   always_comb begin
      state_in = state_ff; idx_in = idx_ff; pass_in = pass_ff; rest_in = rest_ff;
      col_in = col_ff; sp_in = sp_ff; rv_in = 1'b0;
      ra_in = AW'(idx_ff); prev_in = prev_ff; hp_in = hp_ff; pspd_in = pspd_ff;
      padd_in = padd_ff; pa_in = pa_ff; pull_in = pull_ff; drag_in = drag_ff;
      slv_in = slv_ff; ssp_in = ssp_ff; sa_in = sa_ff; s2_in = 1'b0;
      ov_in = ov_ff; oa_in = oa_ff; ol_in = ol_ff; ol_last_in = ol_last_ff;
      wr_en = 1'b0; wr_addr = '0; wr_data = '0; rd_addr = AW'(idx_ff);
      req_stall = 1'b1; d = '0; q = '0; tot = '0; nspd = '0; nlv = '0; tmp = '0;
      out_free = !ov_ff || !rsp_stall;
      if (ov_ff && !rsp_stall) ov_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               col_in = AW'(req_column); sp_in = req_splash_speed;
               idx_in = '0; pass_in = '0; hp_in = 1'b0;
               unique case (mode_type'(req_mode))
                  MODE_TICK: state_in = ST_SPRING;
                  MODE_SPLASH: begin
                     state_in = (CW'(req_column) < n && 32'(req_column) < MAX_COLUMNS)
                        ? ST_SPLASH : ST_IDLE;
                     idx_in = CW'(req_column);
                  end
                  MODE_RESTART: state_in = ST_RESTART;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_RESTART: begin
            wr_en = 1'b1; wr_addr = AW'(idx_ff);
            wr_data = {1'b0, init_ff, 24'sd0};
            rest_in = {1'b0, init_ff};
            idx_in = idx_ff + 1'b1;
            if (idx_ff == CW'(MAX_COLUMNS - 1)) state_in = ST_IDLE;
         end
         ST_SPLASH: begin
            rd_addr = col_ff;
            if (!rv_ff) rv_in = 1'b1;
            else begin
               wr_en = 1'b1; wr_addr = col_ff;
               wr_data = {rd_lv, sat24(48'(rd_sp) + 48'(sp_ff))};
               if (48'(rest_ff) < 48'($signed({1'b0, ceiling_ff})))
                  rest_in = sat24(48'(rest_ff) + 48'($signed({1'b0, step_ff})));
               state_in = ST_IDLE;
            end
         end
         ST_SPRING: begin
            if (idx_ff < n) begin
               rv_in = 1'b1; idx_in = idx_ff + 1'b1;
            end
            if (rv_ff) begin
               tmp = $signed({1'b0, tension_ff}) * (26'(rest_ff) - 26'(rd_lv));
               pull_in = 40'(tmp >>> 16);
               tmp = $signed({1'b0, damping_ff}) * 26'(rd_sp);
               drag_in = 40'(tmp >>> 16);
               slv_in = rd_lv; ssp_in = rd_sp; sa_in = ra_ff; s2_in = 1'b1;
            end
            if (s2_ff) begin
               nspd = sat24(48'(ssp_ff) + 48'(pull_ff) - 48'(drag_ff));
               nlv = sat24(48'(slv_ff) + 48'(nspd));
               wr_en = 1'b1; wr_addr = sa_ff; wr_data = {nlv, nspd};
            end
            if (idx_ff >= n && !rv_ff && !s2_ff) begin
               idx_in = '0;
               state_in = (n > CW'(1) && SPREAD_PASSES > 0) ? ST_SPREAD : ST_EMIT;
            end
         end
         ST_SPREAD: begin
            // reads run one column ahead; column k is written once k+1 is read
            if (idx_ff < n) begin
               rv_in = 1'b1; idx_in = idx_ff + 1'b1;
            end
            if (rv_ff) begin
               if (hp_ff) begin
                  d = 26'(rd_lv) - 26'(prev_ff);
                  q = d >>> 2;
                  tot = padd_ff + q;
                  wr_en = 1'b1; wr_addr = pa_ff;
                  wr_data = {sat24(48'(prev_ff) + 48'(tot)),
                             sat24(48'(pspd_ff) + 48'(tot))};
                  padd_in = (-d) >>> 2;
               end else padd_in = '0;
               prev_in = rd_lv; pspd_in = rd_sp; pa_in = ra_ff; hp_in = 1'b1;
            end else if (idx_ff >= n && hp_ff) begin
               wr_en = 1'b1; wr_addr = pa_ff;
               wr_data = {sat24(48'(prev_ff) + 48'(padd_ff)),
                          sat24(48'(pspd_ff) + 48'(padd_ff))};
               hp_in = 1'b0; idx_in = '0;
               pass_in = pass_ff + 1'b1;
               if (32'(pass_ff) == SPREAD_PASSES - 1) state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rv_ff) begin
               ov_in = 1'b1; oa_in = ra_ff; ol_in = rd_lv;
               ol_last_in = (CW'(ra_ff) == n - 1'b1);
            end
            if (!rv_ff && out_free) begin
               if (idx_ff < n) begin
                  rv_in = 1'b1; idx_in = idx_ff + 1'b1;
               end else if (!ov_in) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = ov_ff;
   assign rsp_column_index = 6'(oa_ff);
   assign rsp_level = ol_ff;
   assign rsp_last = ol_last_ff;
endmodule
`default_nettype wire

### bench/testbench.sv
`default_nettype none
module testbench;
   import swss_pkg::*;

   localparam int MaxCols = 64;
   localparam int Passes = 8;
   localparam int SettleCycles = 120;
   localparam int EndCycles = 800;
   localparam logic [2:0] CsrBeyondLow = 3'd6;
   localparam logic [2:0] CsrBeyondHigh = 3'd7;

   typedef enum logic [1:0] {
      JOB_ITEM,
      JOB_CSR,
      JOB_DRAIN
   } job_kind_type;

   typedef struct {
      job_kind_type kind;
      mode_type mode;
      logic [5:0] column;
      logic signed [23:0] speed;
      logic [2:0] idx;
      logic [22:0] data;
   } job_type;

   typedef struct {
      logic [5:0] column;
      logic signed [23:0] level;
      logic last;
   } level_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_mode = MODE_TICK;
   logic [5:0] req_column = '0;
   logic signed [23:0] req_splash_speed = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [5:0] rsp_column_index;
   logic signed [23:0] rsp_level;
   logic rsp_last;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = CSR_COUNT;
   logic [22:0] csr_data = '0;

   spring_water_surface_sim_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_column(req_column), .req_splash_speed(req_splash_speed),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_column_index(rsp_column_index), .rsp_level(rsp_level), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // surface state mirror
   logic [6:0] cfg_count = 7'd64;
   logic [15:0] cfg_tension = 16'd1638;
   logic [15:0] cfg_damping = 16'd1638;
   logic [22:0] cfg_initial = 23'd2048;
   logic [22:0] cfg_ceiling = 23'd43008;
   logic [15:0] cfg_step = 16'd32;
   logic signed [23:0] col_level [MaxCols];
   logic signed [23:0] col_speed [MaxCols];
   logic signed [23:0] rest_level;

   job_type pending [$];
   level_report_type levels_due [$];
   int mismatches = 0;

   function automatic logic signed [23:0] clamp24(input longint v);
      if (v > 64'sd8388607) return 24'sh7FFFFF;
      if (v < -64'sd8388608) return -24'sh800000;
      return v[23:0];
   endfunction

   function automatic void restart_surface();
      rest_level = clamp24(longint'(cfg_initial));
      for (int i = 0; i < MaxCols; i++) begin
         col_level[i] = rest_level;
         col_speed[i] = '0;
      end
   endfunction

   initial restart_surface();

   function automatic void write_registers(input logic [2:0] idx, input logic [22:0] data);
      case (idx)
         CSR_COUNT: cfg_count = data[6:0];
         CSR_TENSION: cfg_tension = data[15:0];
         CSR_DAMPING: cfg_damping = data[15:0];
         CSR_INIT: cfg_initial = data;
         CSR_CEILING: cfg_ceiling = data;
         CSR_STEP: cfg_step = data[15:0];
         default: ;
      endcase
   endfunction

   function automatic void advance_surface(input job_type j);
      int n;
      longint lv, sv, pull, drag;
      longint snap [MaxCols];
      longint add [MaxCols];
      level_report_type r;
      n = (cfg_count < 1) ? 1 : (cfg_count > MaxCols) ? MaxCols : int'(cfg_count);
      case (j.mode)
         MODE_RESTART: restart_surface();
         MODE_SPLASH: begin
            if (j.column < n) begin
               col_speed[j.column] = clamp24(longint'(col_speed[j.column]) + longint'(j.speed));
               if (longint'(rest_level) < longint'(cfg_ceiling))
                  rest_level = clamp24(longint'(rest_level) + longint'(cfg_step));
            end
         end
         MODE_TICK: begin
            for (int i = 0; i < n; i++) begin
               lv = col_level[i];
               sv = col_speed[i];
               pull = (longint'(cfg_tension) * (longint'(rest_level) - lv)) >>> 16;
               drag = (longint'(cfg_damping) * sv) >>> 16;
               col_speed[i] = clamp24(sv + pull - drag);
               col_level[i] = clamp24(lv + longint'(col_speed[i]));
            end
            for (int p = 0; p < Passes; p++) begin
               for (int i = 0; i < n; i++) begin
                  snap[i] = col_level[i];
                  add[i] = 0;
               end
               for (int i = 0; i + 1 < n; i++) begin
                  add[i + 1] += (snap[i] - snap[i + 1]) >>> 2;
                  add[i] += (snap[i + 1] - snap[i]) >>> 2;
               end
               for (int i = 0; i < n; i++) begin
                  col_speed[i] = clamp24(longint'(col_speed[i]) + add[i]);
                  col_level[i] = clamp24(snap[i] + add[i]);
               end
            end
            for (int i = 0; i < n; i++) begin
               r.column = i[5:0];
               r.level = col_level[i];
               r.last = (i + 1 == n);
               levels_due.push_back(r);
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      mismatches++;
   endtask

   // driver
   job_type cur;
   logic req_next, csr_next;
   int gap = 0;
   int quiet = 0;
   logic send_calm = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         quiet = 0;
      end else begin
         req_next = req_valid;
         csr_next = csr_valid;
         if (req_valid && !req_stall) begin
            advance_surface(cur);
            req_next = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            write_registers(cur.idx, cur.data);
            csr_next = 1'b0;
         end
         if (levels_due.size() == 0 && !req_valid) quiet++;
         else quiet = 0;
         if (!req_next && !csr_next) begin
            if (gap > 0) begin
               gap--;
            end else if (pending.size() > 0) begin
               if (pending[0].kind == JOB_ITEM) begin
                  cur = pending.pop_front();
                  req_mode <= cur.mode;
                  req_column <= cur.column;
                  req_splash_speed <= cur.speed;
                  req_next = 1'b1;
                  if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
                  gap = send_calm ? 0 : $urandom_range(0, 10);
               end else if (quiet >= SettleCycles) begin
                  cur = pending.pop_front();
                  if (cur.kind == JOB_CSR) begin
                     csr_index <= cur.idx;
                     csr_data <= cur.data;
                     csr_next = 1'b1;
                  end
               end
            end
         end
         req_valid <= req_next;
         csr_valid <= csr_next;
      end
   end

   // monitor
   int hold = 0;
   logic recv_calm = 1'b0;
   level_report_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (levels_due.size() == 0) begin
               report("unexpected transaction, column", rsp_column_index, -1);
            end else begin
               want = levels_due.pop_front();
               if (rsp_column_index !== want.column)
                  report("column_index", rsp_column_index, want.column);
               if (rsp_level !== want.level) report("level", rsp_level, want.level);
               if (rsp_last !== want.last) report("last", rsp_last, want.last);
            end
            if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
            hold = recv_calm ? 0 : $urandom_range(0, 10);
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic add_item(input mode_type m, input logic [5:0] c, input logic signed [23:0] s);
      job_type j;
      j.kind = JOB_ITEM;
      j.mode = m;
      j.column = c;
      j.speed = s;
      j.idx = '0;
      j.data = '0;
      pending.push_back(j);
   endtask

   task automatic add_write(input logic [2:0] idx, input logic [22:0] data);
      job_type j;
      j.kind = JOB_CSR;
      j.mode = MODE_TICK;
      j.column = '0;
      j.speed = '0;
      j.idx = idx;
      j.data = data;
      pending.push_back(j);
   endtask

   task automatic add_drain();
      job_type j;
      j.kind = JOB_DRAIN;
      j.mode = MODE_TICK;
      j.column = '0;
      j.speed = '0;
      j.idx = '0;
      j.data = '0;
      pending.push_back(j);
   endtask

   function automatic mode_type pick_mode();
      int r;
      r = $urandom_range(0, 19);
      if (r < 8) return MODE_TICK;
      if (r < 17) return MODE_SPLASH;
      if (r < 19) return MODE_RESTART;
      return MODE_NONE;
   endfunction

   function automatic logic signed [23:0] pick_speed();
      if ($urandom_range(0, 2) == 0) return 24'($urandom());
      return $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
   endfunction

   initial begin
      // directed part at reset settings
      add_item(MODE_TICK, 6'd0, '0);
      add_item(MODE_SPLASH, 6'd0, 24'sh7FFFFF);
      add_item(MODE_TICK, 6'd0, '0);
      add_item(MODE_SPLASH, 6'd63, -24'sh800000);
      add_item(MODE_SPLASH, 6'd31, 24'sh2AAAAA);
      add_item(MODE_TICK, 6'd0, '0);
      add_item(MODE_NONE, 6'd17, 24'sh123456);
      add_item(MODE_TICK, 6'd0, '0);
      add_drain();
      add_item(MODE_RESTART, 6'd0, '0);
      add_item(MODE_TICK, 6'd0, '0);
      // single column, splash outside the columns in use
      add_write(CSR_COUNT, 23'd1);
      add_item(MODE_SPLASH, 6'd0, 24'sh001000);
      add_item(MODE_SPLASH, 6'd5, 24'sh001000);
      add_item(MODE_TICK, 6'd0, '0);
      add_write(CSR_COUNT, 23'd0);
      add_item(MODE_TICK, 6'd0, '0);
      add_write(CSR_COUNT, 23'h7FFFFF);
      add_write(CsrBeyondLow, 23'd3);
      add_write(CsrBeyondHigh, 23'd5);
      add_item(MODE_TICK, 6'd0, '0);
      // saturation extremes
      add_write(CSR_COUNT, 23'd2);
      add_write(CSR_TENSION, 23'hFFFF);
      add_write(CSR_DAMPING, 23'd0);
      add_write(CSR_INIT, 23'h7FFFFF);
      add_write(CSR_CEILING, 23'h7FFFFF);
      add_write(CSR_STEP, 23'hFFFF);
      add_item(MODE_RESTART, 6'd0, '0);
      add_item(MODE_SPLASH, 6'd1, 24'sh7FFFFF);
      add_item(MODE_TICK, 6'd0, '0);
      add_item(MODE_SPLASH, 6'd0, -24'sh800000);
      add_item(MODE_TICK, 6'd0, '0);
      add_write(CSR_TENSION, 23'd0);
      add_write(CSR_DAMPING, 23'hFFFF);
      add_write(CSR_INIT, 23'd0);
      add_write(CSR_CEILING, 23'd0);
      add_write(CSR_STEP, 23'd0);
      add_item(MODE_RESTART, 6'd0, '0);
      add_item(MODE_SPLASH, 6'd1, 24'sh400000);
      add_item(MODE_TICK, 6'd0, '0);
      add_item(MODE_TICK, 6'd0, '0);
      // random phases
      for (int ph = 0; ph < 5; ph++) begin
         add_write(CSR_COUNT, (ph == 2) ? 23'd64 : 23'($urandom_range(0, 18)));
         add_write(CSR_TENSION, 23'($urandom()));
         add_write(CSR_DAMPING, 23'($urandom()));
         add_write(CSR_INIT, ($urandom_range(0, 1) != 0) ? 23'($urandom()) :
                   23'($urandom_range(0, 65535)));
         add_write(CSR_CEILING, 23'($urandom()));
         add_write(CSR_STEP, 23'($urandom()));
         add_item(MODE_RESTART, 6'd0, '0);
         for (int k = 0; k < 20; k++) begin
            if ($urandom_range(0, 12) == 0) add_drain();
            add_item(pick_mode(),
                     ($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 15)),
                     pick_speed());
         end
         add_item(MODE_TICK, 6'd0, '0);
         add_drain();
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock);
      while (pending.size() != 0 || req_valid || csr_valid || levels_due.size() != 0);
      repeat (EndCycles) @(posedge clock);
      if (mismatches == 0 && levels_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
`default_nettype wire
